// ----- src/mfb_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, codes and helpers of the monochrome framebuffer draw engine.
// No dependencies.
package mfb_pkg;

  localparam int DEF_SCREEN_WIDTH = 128;
  localparam int DEF_SCREEN_PAGES = 8;
  localparam int SLOPE_SCALE      = 10;

  localparam logic [2:0] ACT_SET    = 3'd0;
  localparam logic [2:0] ACT_CLR    = 3'd1;
  localparam logic [2:0] ACT_LINE   = 3'd2;
  localparam logic [2:0] ACT_CIRCLE = 3'd3;
  localparam logic [2:0] ACT_CLS    = 3'd4;
  localparam logic [2:0] ACT_READ   = 3'd5;

  typedef enum logic [3:0] {
    K_NOP, K_SET, K_CLR, K_LREJ, K_LVERT, K_LHORZ, K_LSLOPE, K_CIRCLE, K_CLS, K_READ
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] x0;
    logic [6:0] y0;
    logic [7:0] x1;
    logic [6:0] y1;
    logic [6:0] radius;
    logic [2:0] page;
  } cmd_t;

  typedef struct packed {
    logic pop;
    logic init_busy;
  } ctl_t;

  // Quotient by ten for values below 320 (the quotient must fit in five bits).
  function automatic logic [4:0] div10(input logic [8:0] v);
    logic [19:0] p;
    p = 20'(v) * 20'd205;
    return p[15:11];
  endfunction

endpackage

// ----- src/mfb_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts command words, classifies them and holds them in a
// two-entry queue for the back end. Depends on mfb_pkg.
module mfb_front #(
  parameter int SCREEN_WIDTH = mfb_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_PAGES = mfb_pkg::DEF_SCREEN_PAGES
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [2:0]    action,
  input  logic [7:0]    x0,
  input  logic [6:0]    y0,
  input  logic [7:0]    x1,
  input  logic [6:0]    y1,
  input  logic [6:0]    radius,
  input  logic [2:0]    read_page,
  input  mfb_pkg::ctl_t ctl,
  output logic          q_valid,
  output mfb_pkg::cmd_t q_head
);
  import mfb_pkg::*;

  localparam int SCREEN_HEIGHT = SCREEN_PAGES * 8;

  cmd_t       slots [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  cmd_t       cls;
  logic       reject;
  logic       push;

  assign reject = ({1'b0, x1} > 9'(SCREEN_WIDTH)) || ({1'b0, y1} > 8'(SCREEN_HEIGHT))
                  || (x0 > x1) || (y0 > y1);

  always_comb begin
    cls.x0     = x0;
    cls.y0     = y0;
    cls.x1     = x1;
    cls.y1     = y1;
    cls.radius = radius;
    cls.page   = read_page;
    unique case (action)
      ACT_SET:    cls.kind = K_SET;
      ACT_CLR:    cls.kind = K_CLR;
      ACT_LINE: begin
        if (reject)        cls.kind = K_LREJ;
        else if (x0 == x1) cls.kind = K_LVERT;
        else if (y0 == y1) cls.kind = K_LHORZ;
        else               cls.kind = K_LSLOPE;
      end
      ACT_CIRCLE: cls.kind = K_CIRCLE;
      ACT_CLS:    cls.kind = K_CLS;
      ACT_READ:   cls.kind = K_READ;
      default:    cls.kind = K_NOP;
    endcase
  end

  // Hold off new words while the queue is full or the screen is being wiped after reset.
  assign in_stall = (count == 2'd2) || ctl.init_busy;
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != 2'd0);
  assign q_head   = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= cls;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push)    wptr <= ~wptr;
      if (ctl.pop) rptr <= ~rptr;
      count <= count + 2'(push) - 2'(ctl.pop);
    end
  end

endmodule

// ----- src/mfb_back.sv -----
`timescale 1ns / 1ps
// Back end: runs queued commands against the framebuffer memory and holds
// the result word for the output channel. Depends on mfb_pkg.
module mfb_back #(
  parameter int SCREEN_WIDTH = mfb_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_PAGES = mfb_pkg::DEF_SCREEN_PAGES
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  mfb_pkg::cmd_t q_head,
  output mfb_pkg::ctl_t ctl,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    read_byte,
  output logic          status
);
  import mfb_pkg::*;

  localparam int SCREEN_HEIGHT = SCREEN_PAGES * 8;
  localparam int DEPTH         = SCREEN_WIDTH * SCREEN_PAGES;
  localparam int AW            = $clog2(DEPTH);

  typedef enum logic [13:0] {
    ST_INIT   = 14'b00000000000001,
    ST_IDLE   = 14'b00000000000010,
    ST_DISP   = 14'b00000000000100,
    ST_CLEAR  = 14'b00000000001000,
    ST_DIV    = 14'b00000000010000,
    ST_LINE   = 14'b00000000100000,
    ST_LSTEP  = 14'b00000001000000,
    ST_CCHK   = 14'b00000010000000,
    ST_CPT    = 14'b00000100000000,
    ST_CUPD   = 14'b00001000000000,
    ST_PXRD   = 14'b00010000000000,
    ST_PXWR   = 14'b00100000000000,
    ST_RDWAIT = 14'b01000000000000,
    ST_DONE   = 14'b10000000000000
  } state_t;

  state_t      state;
  state_t      ret;
  cmd_t        cur;
  logic [7:0]  mem [DEPTH];
  logic [7:0]  rdata;
  logic        mem_we;
  logic [AW-1:0] mem_addr;
  logic [7:0]  mem_wdata;
  logic [AW-1:0] sweep;
  logic [9:0]  px;
  logic [9:0]  py;
  logic        pon;
  logic [AW-1:0] px_addr;
  logic [AW-1:0] pix_addr;
  logic [AW-1:0] rd_addr;
  logic [2:0]  pbit;
  logic        clipped;
  logic [9:0]  lx;
  logic [9:0]  ly;
  logic [8:0]  lcnt;
  logic [7:0]  k;
  logic [3:0]  lrem;
  logic [10:0] dquot;
  logic [8:0]  drem;
  logic [3:0]  dcnt;
  logic [8:0]  drem_sh;
  logic [7:0]  dx;
  logic [6:0]  dy;
  logic [7:0]  ca;
  logic [7:0]  cb;
  logic [15:0] cb_sq;
  logic [13:0] rr;
  logic [2:0]  cidx;
  logic [9:0]  cxa_p, cxa_m, cxb_p, cxb_m, cya_p, cya_m, cyb_p, cyb_m;
  logic [8:0]  ssum;
  logic [4:0]  qinc;
  logic [7:0]  ca_inc;
  logic [7:0]  res_byte;
  logic        res_status;
  logic        rd_ok;
  logic [7:0]  pmask;

  assign ctl.pop       = (state == ST_IDLE) && q_valid;
  assign ctl.init_busy = (state == ST_INIT);

  assign dx = cur.x1 - cur.x0;
  assign dy = cur.y1 - cur.y0;

  assign clipped  = px[9] || (px[8:0] >= 9'(SCREEN_WIDTH))
                    || py[9] || (py[8:0] >= 9'(SCREEN_HEIGHT));
  assign pix_addr = AW'(int'(px[8:0]) * SCREEN_PAGES + int'(py[8:3]));
  assign rd_addr  = AW'(int'(cur.x0) * SCREEN_PAGES + int'(cur.page));
  assign rd_ok    = ({1'b0, cur.x0} < 9'(SCREEN_WIDTH)) && ({2'b00, cur.page} < 5'(SCREEN_PAGES));
  assign pmask    = 8'd1 << pbit;

  assign drem_sh = {drem[7:0], dquot[10]};
  assign ssum    = {5'd0, lrem} + {1'b0, k};
  assign qinc    = div10(ssum);
  assign ca_inc  = ca + 8'd1;
  assign cb_sq   = 16'(cb) * 16'(cb);

  assign cxa_p = {2'b00, cur.x0} + {2'b00, ca};
  assign cxa_m = {2'b00, cur.x0} - {2'b00, ca};
  assign cxb_p = {2'b00, cur.x0} + {2'b00, cb};
  assign cxb_m = {2'b00, cur.x0} - {2'b00, cb};
  assign cya_p = {3'b000, cur.y0} + {2'b00, ca};
  assign cya_m = {3'b000, cur.y0} - {2'b00, ca};
  assign cyb_p = {3'b000, cur.y0} + {2'b00, cb};
  assign cyb_m = {3'b000, cur.y0} - {2'b00, cb};

  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = 8'd0;
    mem_addr  = sweep;
    if (state == ST_PXWR) begin
      mem_we    = 1'b1;
      mem_addr  = px_addr;
      mem_wdata = pon ? (rdata | pmask) : (rdata & ~pmask);
    end else if (state == ST_INIT || state == ST_CLEAR) begin
      mem_we = 1'b1;
    end else if (state == ST_PXRD) begin
      mem_addr = pix_addr;
    end else if (state == ST_DISP) begin
      mem_addr = rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    rdata <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      sweep     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != ST_DONE) out_valid <= 1'b0;
      unique case (state)
        ST_INIT, ST_CLEAR: begin
          sweep <= sweep + AW'(1);
          if (sweep == AW'(DEPTH - 1)) begin
            sweep <= '0;
            state <= (state == ST_INIT) ? ST_IDLE : ST_DONE;
          end
        end
        ST_IDLE: begin
          if (q_valid) begin
            cur   <= q_head;
            state <= ST_DISP;
          end
        end
        ST_DISP: begin
          res_byte   <= 8'd0;
          res_status <= 1'b0;
          lx   <= {2'b00, cur.x0};
          ly   <= {3'b000, cur.y0};
          lrem <= 4'd0;
          px   <= {2'b00, cur.x0};
          py   <= {3'b000, cur.y0};
          pon  <= 1'b1;
          ret  <= ST_DONE;
          case (cur.kind)
            K_SET:    state <= ST_PXRD;
            K_CLR: begin
              pon   <= 1'b0;
              state <= ST_PXRD;
            end
            K_LREJ: begin
              res_status <= 1'b1;
              state      <= ST_DONE;
            end
            K_LVERT: begin
              lcnt  <= {2'b00, dy};
              state <= ST_LINE;
            end
            K_LHORZ: begin
              lcnt  <= {1'b0, dx};
              state <= ST_LINE;
            end
            K_LSLOPE: begin
              lcnt  <= {1'b0, dx};
              dquot <= 11'({dy, 3'b000}) + 11'({dy, 1'b0});
              drem  <= 9'd0;
              dcnt  <= 4'd0;
              state <= ST_DIV;
            end
            K_CIRCLE: begin
              ca    <= 8'd0;
              cb    <= {1'b0, cur.radius};
              rr    <= 14'(cur.radius * cur.radius);
              // A zero radius plots the centre only.
              state <= (cur.radius == 7'd0) ? ST_PXRD : ST_CCHK;
            end
            K_CLS:  state <= ST_CLEAR;
            K_READ: state <= rd_ok ? ST_RDWAIT : ST_DONE;
            default: state <= ST_DONE;
          endcase
        end
        ST_DIV: begin
          if (drem_sh >= {1'b0, dx}) begin
            drem  <= drem_sh - {1'b0, dx};
            dquot <= {dquot[9:0], 1'b1};
          end else begin
            drem  <= drem_sh;
            dquot <= {dquot[9:0], 1'b0};
          end
          dcnt <= dcnt + 4'd1;
          if (dcnt == 4'd10) state <= ST_LINE;
        end
        ST_LINE: begin
          // Quotient is final here for sloped lines: keep its low byte.
          k <= dquot[7:0];
          if (lcnt == 9'd0) begin
            state <= ST_DONE;
          end else begin
            px    <= lx;
            py    <= ly;
            ret   <= ST_LSTEP;
            state <= ST_PXRD;
          end
        end
        ST_LSTEP: begin
          lcnt <= lcnt - 9'd1;
          case (cur.kind)
            K_LVERT: ly <= ly + 10'd1;
            K_LHORZ: lx <= lx + 10'd1;
            default: begin
              lx   <= lx + 10'd1;
              ly   <= ly + 10'(qinc);
              lrem <= 4'(ssum - 9'(qinc) * 9'(SLOPE_SCALE));
            end
          endcase
          state <= ST_LINE;
        end
        ST_CCHK: begin
          cidx  <= 3'd0;
          state <= ({1'b0, cb_sq, 1'b0} >= {4'd0, rr}) ? ST_CPT : ST_DONE;
        end
        ST_CPT: begin
          case (cidx)
            3'd0: begin px <= cxa_p; py <= cyb_m; end
            3'd1: begin px <= cxa_m; py <= cyb_m; end
            3'd2: begin px <= cxa_m; py <= cyb_p; end
            3'd3: begin px <= cxa_p; py <= cyb_p; end
            3'd4: begin px <= cxb_p; py <= cya_p; end
            3'd5: begin px <= cxb_p; py <= cya_m; end
            3'd6: begin px <= cxb_m; py <= cya_m; end
            default: begin px <= cxb_m; py <= cya_p; end
          endcase
          cidx  <= cidx + 3'd1;
          ret   <= (cidx == 3'd7) ? ST_CUPD : ST_CPT;
          state <= ST_PXRD;
        end
        ST_CUPD: begin
          // Step along a; when the point leaves the circle, step b in instead.
          if (17'(ca_inc * ca_inc) + 17'(cb * cb) > 17'(rr)) cb <= cb - 8'd1;
          else ca <= ca_inc;
          state <= ST_CCHK;
        end
        ST_PXRD: begin
          px_addr <= pix_addr;
          pbit    <= py[2:0];
          state   <= clipped ? ret : ST_PXWR;
        end
        ST_PXWR: state <= ret;
        ST_RDWAIT: begin
          res_byte <= rdata;
          state    <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            read_byte <= res_byte;
            status    <= res_status;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- src/mono_framebuffer_draw_engine_core.sv -----
`timescale 1ns / 1ps
// Top level of the monochrome framebuffer draw engine: front end with queue,
// back end with framebuffer memory. Depends on mfb_pkg, mfb_front, mfb_back.
//
// A page-ordered one-bit framebuffer of SCREEN_WIDTH columns by SCREEN_PAGES
// pages (each byte is eight vertical pixels, top pixel in bit 0) with a pixel,
// line and circle engine. Every command word yields exactly one result word
// (read_byte, status). The front end queues up to two command words while the
// back end works, so the input side can still take words while a result waits,
// until the queue is full. Cost is set by the single-port framebuffer memory,
// where each plotted pixel is a read-modify-write; a clipped pixel skips the
// write. A sloped line first runs 11 divider steps, a circle plots eight points
// per step, and a clear screen writes every byte. After reset the memory is
// wiped, all SCREEN_WIDTH*SCREEN_PAGES bytes (1024 by default), during which
// in_stall stays high. Off-screen points are dropped; out-of-range reads give 0.
module mono_framebuffer_draw_engine_core #(
  parameter int SCREEN_WIDTH = mfb_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_PAGES = mfb_pkg::DEF_SCREEN_PAGES
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] action,
  input  logic [7:0] x0,
  input  logic [6:0] y0,
  input  logic [7:0] x1,
  input  logic [6:0] y1,
  input  logic [6:0] radius,
  input  logic [2:0] read_page,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] read_byte,
  output logic       status
);
  import mfb_pkg::*;

  ctl_t ctl;
  logic q_valid;
  cmd_t q_head;

  // Classify and queue incoming command words.
  mfb_front #(
    .SCREEN_WIDTH(SCREEN_WIDTH),
    .SCREEN_PAGES(SCREEN_PAGES)
  ) u_front (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .x0(x0), .y0(y0), .x1(x1), .y1(y1),
    .radius(radius), .read_page(read_page),
    .ctl(ctl), .q_valid(q_valid), .q_head(q_head)
  );

  // Execute commands and hold the result word.
  mfb_back #(
    .SCREEN_WIDTH(SCREEN_WIDTH),
    .SCREEN_PAGES(SCREEN_PAGES)
  ) u_back (
    .clk(clk), .rst(rst),
    .q_valid(q_valid), .q_head(q_head), .ctl(ctl),
    .out_valid(out_valid), .out_stall(out_stall),
    .read_byte(read_byte), .status(status)
  );

  a_no_accept_in_wipe: assert property (@(posedge clk) disable iff (rst)
    ctl.init_busy |-> !(in_valid && !in_stall))
    else $error("word accepted during memory wipe");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    ctl.pop |-> q_valid)
    else $error("queue popped while empty");

  a_reject_no_byte: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status) |-> (read_byte == 8'd0))
    else $error("rejected line carries read data");

endmodule
